FILE: rtl/tcbd_pkg.sv
// Shared types, constants, conversion helpers and the control store of the
// tilt-compensated brake detector. No dependencies.
`default_nettype none
package tcbd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int CNT_BITS    = $clog2(SAMPLE_BITS + 1);
   localparam int MAG_BITS    = (SAMPLE_BITS + 1 > 15) ? SAMPLE_BITS + 1 : 15;
   localparam int STEP_BITS   = 5;

   localparam logic [1:0] CSR_THRESHOLD      = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_DIVISOR = 2'd1;
   localparam logic [1:0] CSR_PITCH_DIVISOR  = 2'd2;

   localparam logic [STEP_BITS-1:0] STEP_COMPENSATE = STEP_BITS'(9);
   localparam logic [STEP_BITS-1:0] STEP_RATIO_MUL  = STEP_BITS'(13);

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_z;
      logic               refresh_pitch;
   } req_type;

   typedef struct packed {
      logic               light_on;
      logic signed [15:0] smoothed_z;
   } rsp_type;

   typedef struct packed {
      logic [14:0] detect_threshold;
      logic [6:0]  sample_divisor;
      logic [6:0]  pitch_divisor;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_DIV,
      OP_MULQ,
      OP_ADDQ,
      OP_SUBZ,
      OP_CLRR,
      OP_MOVQR,
      OP_MULRU,
      OP_SUBU,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SRC_PX,
      SRC_PZ,
      SRC_FZ,
      SRC_X,
      SRC_Z,
      SRC_U
   } src_type;

   typedef enum logic [1:0] {
      DVS_PITCH,
      DVS_SAMPLE,
      DVS_PX
   } dvs_type;

   typedef enum logic [1:0] {
      DST_PX,
      DST_PZ,
      DST_FZ
   } dst_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_NOREF,
      BR_WAIT,
      BR_PXZERO,
      BR_DONE
   } br_type;

   typedef struct packed {
      op_type                 op;
      src_type                src;
      dvs_type                dvs;
      dst_type                dst;
      br_type                 br;
      logic [STEP_BITS-1:0]   target;
   } ctrl_type;

   typedef struct packed {
      logic refresh;
      logic px_zero;
      logic div_done;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic                          start;
      logic signed [SAMPLE_BITS-1:0] dividend;
      logic signed [SAMPLE_BITS:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [SAMPLE_BITS-1:0] from16(logic signed [15:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      return e[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [15:0] to16(logic signed [SAMPLE_BITS-1:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      return e[15:0];
   endfunction

   function automatic ctrl_type cw(op_type op, src_type src, dvs_type dvs, dst_type dst,
                                   br_type br, logic [STEP_BITS-1:0] target);
      ctrl_type c;
      c.op     = op;
      c.src    = src;
      c.dvs    = dvs;
      c.dst    = dst;
      c.br     = br;
      c.target = target;
      return c;
   endfunction

   function automatic ctrl_type microcode(logic [STEP_BITS-1:0] pc);
      ctrl_type c;
      case (pc)
         5'd0:    c = cw(OP_NONE,  SRC_PX, DVS_PITCH,  DST_PX, BR_NOREF,  STEP_COMPENSATE);
         5'd1:    c = cw(OP_DIV,   SRC_PX, DVS_PITCH,  DST_PX, BR_NEXT,   '0);
         5'd2:    c = cw(OP_MULQ,  SRC_PX, DVS_PITCH,  DST_PX, BR_WAIT,   '0);
         5'd3:    c = cw(OP_DIV,   SRC_X,  DVS_PITCH,  DST_PX, BR_NEXT,   '0);
         5'd4:    c = cw(OP_ADDQ,  SRC_X,  DVS_PITCH,  DST_PX, BR_WAIT,   '0);
         5'd5:    c = cw(OP_DIV,   SRC_PZ, DVS_PITCH,  DST_PZ, BR_NEXT,   '0);
         5'd6:    c = cw(OP_MULQ,  SRC_PZ, DVS_PITCH,  DST_PZ, BR_WAIT,   '0);
         5'd7:    c = cw(OP_DIV,   SRC_Z,  DVS_PITCH,  DST_PZ, BR_NEXT,   '0);
         5'd8:    c = cw(OP_ADDQ,  SRC_Z,  DVS_PITCH,  DST_PZ, BR_WAIT,   '0);
         5'd9:    c = cw(OP_SUBZ,  SRC_Z,  DVS_PX,     DST_FZ, BR_NEXT,   '0);
         5'd10:   c = cw(OP_CLRR,  SRC_PZ, DVS_PX,     DST_FZ, BR_PXZERO, STEP_RATIO_MUL);
         5'd11:   c = cw(OP_DIV,   SRC_PZ, DVS_PX,     DST_FZ, BR_NEXT,   '0);
         5'd12:   c = cw(OP_MOVQR, SRC_PZ, DVS_PX,     DST_FZ, BR_WAIT,   '0);
         5'd13:   c = cw(OP_MULRU, SRC_U,  DVS_SAMPLE, DST_FZ, BR_NEXT,   '0);
         5'd14:   c = cw(OP_SUBU,  SRC_U,  DVS_SAMPLE, DST_FZ, BR_NEXT,   '0);
         5'd15:   c = cw(OP_DIV,   SRC_FZ, DVS_SAMPLE, DST_FZ, BR_NEXT,   '0);
         5'd16:   c = cw(OP_MULQ,  SRC_FZ, DVS_SAMPLE, DST_FZ, BR_WAIT,   '0);
         5'd17:   c = cw(OP_DIV,   SRC_U,  DVS_SAMPLE, DST_FZ, BR_NEXT,   '0);
         5'd18:   c = cw(OP_ADDQ,  SRC_U,  DVS_SAMPLE, DST_FZ, BR_WAIT,   '0);
         5'd19:   c = cw(OP_EMIT,  SRC_FZ, DVS_SAMPLE, DST_FZ, BR_DONE,   '0);
         default: c = cw(OP_NONE,  SRC_FZ, DVS_SAMPLE, DST_FZ, BR_DONE,   '0);
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/tilt_compensated_brake_detector.sv
// Top level of the tilt-compensated brake detector: configuration registers,
// sequencer, datapath and divider. Depends on tcbd_pkg and the tcbd_* modules.
//
// Usage: present an accelerometer sample on req_data with req_valid; it is
// taken when req_ready is high. One result item leaves on rsp_data with
// rsp_valid and is held until rsp_ready. Items are processed one at a time
// by a microcoded step sequence around a shared one-bit-per-cycle divider.
// An item takes three divisions without a pitch refresh and seven with one
// (one division fewer when the x pitch is zero). A new item is accepted
// only after the previous result has been loaded into the output register
// and the sequencer has returned to idle.
// A finished result waits in the output register; if the receiver stalls,
// the block finishes the next item and then holds it at its last step.
// Configuration writes on csr_* are always accepted and must be issued while
// the block is idle. Synchronous reset clears the pitch and filter state,
// empties the output register and loads threshold 2000, sample divisor 8
// and pitch divisor 16.
`default_nettype none
module tilt_compensated_brake_detector (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  tcbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output tcbd_pkg::rsp_type rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [1:0]        csr_index,
   input  wire  [14:0]       csr_data
);
   import tcbd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   ctrl_type    ctrl;
   status_type  status;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        exec, busy, accept;
   logic        refresh, px_zero, out_free;

   assign csr_ready = 1'b1;
   assign req_ready = !busy;
   assign accept    = req_valid && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:      cfg_in.detect_threshold = csr_data;
            CSR_SAMPLE_DIVISOR: cfg_in.sample_divisor   = csr_data[6:0];
            CSR_PITCH_DIVISOR:  cfg_in.pitch_divisor    = csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold <= 15'd2000;
         cfg_ff.sample_divisor   <= 7'd8;
         cfg_ff.pitch_divisor    <= 7'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign status.refresh  = refresh;
   assign status.px_zero  = px_zero;
   assign status.div_done = div_rsp.done;
   assign status.out_free = out_free;

   tcbd_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .status (status),
      .ctrl   (ctrl),
      .exec   (exec),
      .busy   (busy)
   );

   tcbd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .ctrl      (ctrl),
      .exec      (exec),
      .div_rsp   (div_rsp),
      .div_req   (div_req),
      .refresh   (refresh),
      .px_zero   (px_zero),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tcbd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
`default_nettype wire

FILE: rtl/tcbd_divider.sv
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tcbd_pkg.
`default_nettype none
module tcbd_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  tcbd_pkg::div_req_type div_req,
   output tcbd_pkg::div_rsp_type div_rsp
);
   import tcbd_pkg::*;

   localparam int W = SAMPLE_BITS;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W:0]          rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic signed [W-1:0] q_ff, q_in;

   logic signed [W:0]   a_ext, a_abs, b_abs;
   logic [W:0]          rem_sh;
   logic                ge;

   always_comb begin
      a_ext  = {div_req.dividend[W-1], div_req.dividend};
      a_abs  = a_ext[W] ? -a_ext : a_ext;
      b_abs  = div_req.divisor[W] ? -div_req.divisor : div_req.divisor;
      rem_sh = {rem_ff[W-1:0], quo_ff[W-1]};
      ge     = (rem_sh >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;

      if (!busy_ff) begin
         if (div_req.start) begin
            busy_in = 1'b1;
            cnt_in  = CNT_BITS'(W);
            rem_in  = '0;
            quo_in  = a_abs[W-1:0];
            dvs_in  = b_abs[W-1:0];
            neg_in  = a_ext[W] ^ div_req.divisor[W];
         end
      end else begin
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            q_in    = neg_ff ? -quo_in : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule
`default_nettype wire

FILE: rtl/tcbd_sequencer.sv
// Step counter and control store: fetches one control word per step and
// resolves branches and waits. Depends on tcbd_pkg.
`default_nettype none
module tcbd_sequencer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  tcbd_pkg::status_type status,
   output tcbd_pkg::ctrl_type   ctrl,
   output logic                 exec,
   output logic                 busy
);
   import tcbd_pkg::*;

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] pc_ff, pc_in;

   always_comb begin
      ctrl    = microcode(pc_ff);
      exec    = 1'b0;
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else begin
         case (ctrl.br)
            BR_NEXT: begin
               exec  = 1'b1;
               pc_in = pc_ff + 1'b1;
            end
            BR_NOREF: begin
               exec  = 1'b1;
               pc_in = status.refresh ? pc_ff + 1'b1 : ctrl.target;
            end
            BR_PXZERO: begin
               exec  = 1'b1;
               pc_in = status.px_zero ? ctrl.target : pc_ff + 1'b1;
            end
            BR_WAIT: begin
               if (status.div_done) begin
                  exec  = 1'b1;
                  pc_in = pc_ff + 1'b1;
               end
            end
            BR_DONE: begin
               if (status.out_free) begin
                  exec    = 1'b1;
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

FILE: rtl/tcbd_datapath.sv
// Register file, multiplier, adder and output register driven by the
// control word. Depends on tcbd_pkg.
`default_nettype none
module tcbd_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  tcbd_pkg::req_type     req_data,
   input  tcbd_pkg::cfg_type     cfg,
   input  tcbd_pkg::ctrl_type    ctrl,
   input  wire                   exec,
   input  tcbd_pkg::div_rsp_type div_rsp,
   output tcbd_pkg::div_req_type div_req,
   output logic                  refresh,
   output logic                  px_zero,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output tcbd_pkg::rsp_type     rsp_data
);
   import tcbd_pkg::*;

   localparam int W = SAMPLE_BITS;

   logic signed [W-1:0] xs_ff, xs_in, zs_ff, zs_in;
   logic                ref_ff, ref_in;
   logic signed [W-1:0] px_ff, px_in, pz_ff, pz_in, fz_ff, fz_in;
   logic signed [W-1:0] t_ff, t_in, u_ff, u_in, r_ff, r_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [6:0]          d_raw, d_eff, dm1;
   logic [W-1:0]        mul_a, mul_b;
   logic [2*W-1:0]      prod;
   logic signed [W-1:0] sum;
   logic signed [MAG_BITS-1:0] fz_ext, mag;

   always_comb begin
      d_raw = (ctrl.dvs == DVS_SAMPLE) ? cfg.sample_divisor : cfg.pitch_divisor;
      d_eff = (d_raw == 7'd0) ? 7'd1 : d_raw;
      dm1   = d_eff - 7'd1;

      div_req.start = exec && (ctrl.op == OP_DIV);
      case (ctrl.src)
         SRC_PX:  div_req.dividend = px_ff;
         SRC_PZ:  div_req.dividend = pz_ff;
         SRC_FZ:  div_req.dividend = fz_ff;
         SRC_X:   div_req.dividend = xs_ff;
         SRC_Z:   div_req.dividend = zs_ff;
         default: div_req.dividend = u_ff;
      endcase
      if (ctrl.dvs == DVS_PX) begin
         div_req.divisor = {px_ff[W-1], px_ff};
      end else begin
         div_req.divisor = {{(W-6){1'b0}}, d_eff};
      end

      if (ctrl.op == OP_MULRU) begin
         mul_a = r_ff;
         mul_b = u_ff;
      end else begin
         mul_a = div_rsp.quotient;
         mul_b = W'(dm1);
      end
      prod = mul_a * mul_b;
      sum  = t_ff + div_rsp.quotient;

      fz_ext = MAG_BITS'(fz_ff);
      mag    = fz_ext[MAG_BITS-1] ? -fz_ext : fz_ext;

      xs_in        = xs_ff;
      zs_in        = zs_ff;
      ref_in       = ref_ff;
      px_in        = px_ff;
      pz_in        = pz_ff;
      fz_in        = fz_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      r_in         = r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (load) begin
         xs_in  = from16(req_data.accel_x);
         zs_in  = from16(req_data.accel_z);
         ref_in = req_data.refresh_pitch;
      end

      if (exec) begin
         case (ctrl.op)
            OP_MULQ, OP_MULRU: t_in = prod[W-1:0];
            OP_ADDQ: begin
               case (ctrl.dst)
                  DST_PX:  px_in = sum;
                  DST_PZ:  pz_in = sum;
                  default: fz_in = sum;
               endcase
            end
            OP_SUBZ:  u_in = zs_ff - pz_ff;
            OP_CLRR:  r_in = '0;
            OP_MOVQR: r_in = div_rsp.quotient;
            OP_SUBU:  u_in = u_ff - t_ff;
            OP_EMIT: begin
               rsp_in.light_on   = ($unsigned(mag) > MAG_BITS'(cfg.detect_threshold));
               rsp_in.smoothed_z = to16(fz_ff);
               rsp_valid_in      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff        <= '0;
         pz_ff        <= '0;
         fz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         px_ff        <= px_in;
         pz_ff        <= pz_in;
         fz_ff        <= fz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xs_ff  <= xs_in;
      zs_ff  <= zs_in;
      ref_ff <= ref_in;
      t_ff   <= t_in;
      u_ff   <= u_in;
      r_ff   <= r_in;
      rsp_ff <= rsp_in;
   end

   assign refresh   = ref_ff;
   assign px_zero   = (px_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
